### sv/lsae_pkg.sv
// ----------------------------------------------------------------------------
// lsae_pkg
// types, codes and the color wheel shared by the strip animation engine files
// ----------------------------------------------------------------------------
package lsae_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_OFF   = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // pattern codes
    localparam logic [2:0] PAT_WIPE     = 3'd0;
    localparam logic [2:0] PAT_RAINBOW  = 3'd1;
    localparam logic [2:0] PAT_CYCLE    = 3'd2;
    localparam logic [2:0] PAT_CHASE    = 3'd3;
    localparam logic [2:0] PAT_CHASE_RB = 3'd4;

    // last frame / cycle numbers of the timed patterns
    localparam logic [10:0] RAINBOW_LAST  = 11'd255;
    localparam logic [10:0] CYCLE_LAST    = 11'(256 * 5 - 1);
    localparam logic [10:0] CHASE_LAST    = 11'(10 - 1);
    localparam logic [10:0] CHASE_RB_LAST = 11'(256 - 1);
    localparam logic [1:0]  PHASE_LAST    = 2'd2;

    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [7:0] WHEEL_MAX  = 8'd255;

    // 256-step color wheel, result packed red, green, blue from the top
    function automatic logic [23:0] wheel(input logic [7:0] pos);
        logic [7:0]  p;
        logic [9:0]  p3;
        logic [23:0] rgb;
        p = WHEEL_MAX - pos;
        if (p < WHEEL_SEG1) begin
            p3  = 10'(p) * 10'd3;
            rgb = {WHEEL_MAX - p3[7:0], 8'd0, p3[7:0]};
        end else if (p < WHEEL_SEG2) begin
            p3  = 10'(p - WHEEL_SEG1) * 10'd3;
            rgb = {8'd0, p3[7:0], WHEEL_MAX - p3[7:0]};
        end else begin
            p3  = 10'(p - WHEEL_SEG2) * 10'd3;
            rgb = {p3[7:0], WHEEL_MAX - p3[7:0], 8'd0};
        end
        return rgb;
    endfunction

endpackage

### sv/led_strip_animation_engine_top.sv
// ----------------------------------------------------------------------------
// led_strip_animation_engine_top
// pixel strip animation engine: wipe, rainbow, rainbow cycle and two chases
// ----------------------------------------------------------------------------
// usage
//   slave channel takes command items: tuser holds the opcode (start, frame
//   tick, all off), tdata the pattern code and the packed 24-bit color.
//   a start item only loads the pattern and emits nothing. a frame tick while
//   a pattern runs, and every off item, emit one item per pixel on the master
//   channel, pixel 0 first, tlast on the final pixel, tuser set on every item
//   of the frame that completes the pattern.
// frame flow
//   start and ignored items leave the command side ready. one shared wheel /
//   select unit works on one pixel a cycle while the receiver takes items,
//   fed by the pixel buffer memory whose read port is registered.
//   s_axis_tready is low while a frame is in flight.
// reset
//   synchronous, active low. engine stops, pattern state goes to zero and the
//   pixel buffer reads as all zero through per-pixel valid bits.
// back pressure
//   when m_axis_tready is low the output register holds its item and the
//   pixel sequencer waits; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module led_strip_animation_engine_top #(
    parameter int PIXELS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [2:0] pattern, [26:3] color, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // pixel items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] pixel_index, [12:5] red,
                                        // [20:13] green, [28:21] blue, rest zero
    output logic        m_axis_tlast,   // last_pixel
    output logic [0:0]  m_axis_tuser    // [0] pattern_finished
);

    localparam int IW = $clog2(PIXELS);
    localparam int CW = $clog2(PIXELS + 1);
    localparam logic [CW-1:0] PIX_CNT   = CW'(PIXELS);
    localparam logic [IW-1:0] LAST_IDX  = IW'(PIXELS - 1);
    localparam logic [10:0]   WIPE_LAST = 11'(PIXELS - 1);
    // rainbow cycle offset floor(i*256/PIXELS) is stepped per pixel
    localparam logic [7:0]    RC_STEP_Q = 8'(256 / PIXELS);
    localparam logic [IW-1:0] RC_STEP_R = IW'(256 % PIXELS);
    localparam logic [IW:0]   RC_MOD    = (IW + 1)'(PIXELS);

    // ---------------- state ----------------
    lsae_pkg::t_state r_state, n_state;

    logic [2:0]    r_active;
    logic          r_running;
    logic [10:0]   r_fc;          // wipe pixel, rainbow step or chase cycle
    logic [1:0]    r_phase;       // chase offset
    logic [23:0]   r_color;
    logic          r_frame_off;   // current frame is an off frame

    // pixel buffer memory and its valid bits
    logic [23:0]       r_mem [PIXELS];
    logic [PIXELS-1:0] r_pix_vld;

    // issue counter and read stage
    logic [CW-1:0] r_iss_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [23:0]   r_rd_data;
    logic          r_rd_dv;
    logic [1:0]    r_rd_m3;       // pixel index mod 3
    logic [7:0]    r_rd_q;        // rainbow cycle offset of this pixel
    logic [IW-1:0] r_rd_r;

    // output register
    logic          r_out_vld;
    logic [4:0]    r_out_idx;
    logic [23:0]   r_out_rgb;
    logic          r_out_last;
    logic          r_out_fin;

    // ---------------- input decode ----------------
    lsae_pkg::t_opcode w_op;
    logic [2:0]        w_pat;
    logic [23:0]       w_in_color;

    assign w_op       = lsae_pkg::t_opcode'(s_axis_tuser);
    assign w_pat      = s_axis_tdata[2:0];
    assign w_in_color = s_axis_tdata[26:3];

    // ---------------- sequencer ----------------
    logic w_adv;        // output slot free or being emptied
    logic w_issue;      // a pixel remains to be read
    logic w_start;
    logic w_go;
    logic w_go_off;
    logic w_frame_end;

    assign w_adv   = !r_out_vld || m_axis_tready;
    assign w_issue = r_iss_idx < PIX_CNT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsae_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_start       = 1'b0;
        w_go          = 1'b0;
        w_go_off      = 1'b0;
        w_frame_end   = 1'b0;
        unique case (r_state)
            lsae_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    unique case (w_op)
                        lsae_pkg::OP_START: begin
                            // unknown patterns are dropped
                            w_start = (w_pat <= lsae_pkg::PAT_CHASE_RB);
                        end
                        lsae_pkg::OP_TICK: begin
                            if (r_running) begin
                                w_go    = 1'b1;
                                n_state = lsae_pkg::ST_RUN;
                            end
                        end
                        lsae_pkg::OP_OFF: begin
                            w_go     = 1'b1;
                            w_go_off = 1'b1;
                            n_state  = lsae_pkg::ST_RUN;
                        end
                        lsae_pkg::OP_NONE: begin
                        end
                    endcase
                end
            end
            lsae_pkg::ST_RUN: begin
                if (w_adv && r_rd_vld && (r_rd_idx == LAST_IDX)) begin
                    w_frame_end = 1'b1;
                    n_state     = lsae_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // ---------------- frame-wide terms ----------------
    logic [1:0] w_q;
    logic       w_fin_pat;
    logic       w_fin;
    logic       w_is_chase;

    assign w_q        = (r_phase > lsae_pkg::PHASE_LAST) ? lsae_pkg::PHASE_LAST : r_phase;
    assign w_is_chase = (r_active == lsae_pkg::PAT_CHASE) || (r_active == lsae_pkg::PAT_CHASE_RB);

    always_comb begin
        unique case (r_active)
            lsae_pkg::PAT_WIPE:    w_fin_pat = r_fc >= WIPE_LAST;
            lsae_pkg::PAT_RAINBOW: w_fin_pat = r_fc >= lsae_pkg::RAINBOW_LAST;
            lsae_pkg::PAT_CYCLE:   w_fin_pat = r_fc >= lsae_pkg::CYCLE_LAST;
            lsae_pkg::PAT_CHASE:
                w_fin_pat = (r_fc >= lsae_pkg::CHASE_LAST) && (w_q == lsae_pkg::PHASE_LAST);
            default:
                w_fin_pat = (r_fc >= lsae_pkg::CHASE_RB_LAST) && (w_q == lsae_pkg::PHASE_LAST);
        endcase
    end

    assign w_fin = !r_frame_off && w_fin_pat;

    // ---------------- shared pixel unit ----------------
    logic [23:0] w_old;
    logic        w_hit;
    logic [7:0]  w_rb_pos;
    logic [7:0]  w_rc_pos;
    logic [8:0]  w_cr_sum;
    logic [7:0]  w_cr_pos;
    logic [7:0]  w_wheel_pos;
    logic [23:0] w_wheel_rgb;
    logic [23:0] w_show;
    logic        w_we;
    logic [23:0] w_wdata;

    assign w_old    = r_rd_dv ? r_rd_data : 24'd0;
    assign w_hit    = (r_rd_m3 == w_q);
    assign w_rb_pos = 8'(r_rd_idx) + r_fc[7:0];
    assign w_rc_pos = r_rd_q + r_fc[7:0];
    // chase rainbow: (pixel base + cycle) mod 255, sum stays below 2*255
    assign w_cr_sum = 9'(r_rd_idx) - 9'(r_rd_m3) + 9'(r_fc[7:0]);
    assign w_cr_pos = (w_cr_sum >= 9'(lsae_pkg::WHEEL_MAX))
                    ? 8'(w_cr_sum - 9'(lsae_pkg::WHEEL_MAX)) : w_cr_sum[7:0];

    always_comb begin
        unique case (r_active)
            lsae_pkg::PAT_RAINBOW: w_wheel_pos = w_rb_pos;
            lsae_pkg::PAT_CYCLE:   w_wheel_pos = w_rc_pos;
            default:               w_wheel_pos = w_cr_pos;
        endcase
    end

    assign w_wheel_rgb = lsae_pkg::wheel(w_wheel_pos);

    always_comb begin
        w_show  = w_old;
        w_we    = 1'b0;
        w_wdata = 24'd0;
        if (r_frame_off) begin
            w_show = 24'd0;
            w_we   = 1'b1;
        end else if (w_is_chase) begin
            // lit pixels are shown, then cleared behind the frame
            if (w_hit) begin
                w_show = (r_active == lsae_pkg::PAT_CHASE) ? r_color : w_wheel_rgb;
                w_we   = 1'b1;
            end
        end else if (r_active == lsae_pkg::PAT_WIPE) begin
            w_show  = (11'(r_rd_idx) == r_fc) ? r_color : w_old;
            w_we    = 1'b1;
            w_wdata = w_show;
        end else begin
            w_show  = w_wheel_rgb;
            w_we    = 1'b1;
            w_wdata = w_wheel_rgb;
        end
    end

    // ---------------- read stage bookkeeping ----------------
    logic [1:0]    n_m3;
    logic [7:0]    n_q;
    logic [IW-1:0] n_r;
    logic [IW:0]   w_r_sum;

    assign w_r_sum = {1'b0, r_rd_r} + {1'b0, RC_STEP_R};

    always_comb begin
        if (r_iss_idx == '0) begin
            n_m3 = 2'd0;
            n_q  = 8'd0;
            n_r  = '0;
        end else begin
            n_m3 = (r_rd_m3 == lsae_pkg::PHASE_LAST) ? 2'd0 : r_rd_m3 + 2'd1;
            if (w_r_sum >= RC_MOD) begin
                n_r = IW'(w_r_sum - RC_MOD);
                n_q = r_rd_q + RC_STEP_Q + 8'd1;
            end else begin
                n_r = w_r_sum[IW-1:0];
                n_q = r_rd_q + RC_STEP_Q;
            end
        end
    end

    logic w_mem_re;
    logic w_mem_we;
    logic w_pix_out;

    assign w_pix_out = (r_state == lsae_pkg::ST_RUN) && w_adv && r_rd_vld;
    assign w_mem_re  = (r_state == lsae_pkg::ST_RUN) && w_adv && w_issue;
    assign w_mem_we  = w_pix_out && w_we;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 3'd0;
            r_running   <= 1'b0;
            r_fc        <= 11'd0;
            r_phase     <= 2'd0;
            r_color     <= 24'd0;
            r_frame_off <= 1'b0;
            r_iss_idx   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pix_vld   <= '0;
        end else begin
            if (w_start) begin
                r_active  <= w_pat;
                r_color   <= w_in_color;
                r_fc      <= 11'd0;
                r_phase   <= 2'd0;
                r_running <= 1'b1;
            end
            if (w_go) begin
                r_frame_off <= w_go_off;
                r_iss_idx   <= '0;
            end
            if ((r_state == lsae_pkg::ST_RUN) && w_adv) begin
                r_rd_vld <= w_issue;
                if (w_issue) begin
                    r_iss_idx <= r_iss_idx + CW'(1);
                end
            end
            if (w_adv) begin
                r_out_vld <= w_pix_out;
            end
            if (w_mem_we) begin
                r_pix_vld[r_rd_idx] <= 1'b1;
            end
            if (w_frame_end) begin
                if (r_frame_off) begin
                    r_running <= 1'b0;
                end else begin
                    if (w_is_chase && (w_q < lsae_pkg::PHASE_LAST)) begin
                        r_phase <= w_q + 2'd1;
                    end else begin
                        r_phase <= 2'd0;
                        r_fc    <= r_fc + 11'd1;
                    end
                    if (w_fin) begin
                        r_running <= 1'b0;
                    end
                end
            end
        end
    end

    // ---------------- pixel buffer memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_rd_idx] <= w_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[r_iss_idx[IW-1:0]];
        end
    end

    // ---------------- payload registers ----------------
    logic [IW+4:0] w_idx_ext;

    assign w_idx_ext = {5'd0, r_rd_idx};

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_rd_idx <= r_iss_idx[IW-1:0];
            r_rd_dv  <= r_pix_vld[r_iss_idx[IW-1:0]];
            r_rd_m3  <= n_m3;
            r_rd_q   <= n_q;
            r_rd_r   <= n_r;
        end
        if (w_pix_out) begin
            r_out_idx  <= w_idx_ext[4:0];
            r_out_rgb  <= w_show;
            r_out_last <= (r_rd_idx == LAST_IDX);
            r_out_fin  <= w_fin;
        end
    end

    // ---------------- outputs ----------------
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'd0, r_out_rgb[7:0], r_out_rgb[15:8], r_out_rgb[23:16], r_out_idx};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_fin;

endmodule

### sv/lsae_checker.sv
// ----------------------------------------------------------------------------
// lsae_checker
// port-level checks of the strip animation engine, bound to its top level
// ----------------------------------------------------------------------------
module lsae_checker #(
    parameter int PIXELS = 31
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    localparam logic [4:0] LAST_IDX5 = 5'(PIXELS - 1);

    logic w_in_acc;
    logic w_pattern_ok;

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_pattern_ok = s_axis_tdata[2:0] <= lsae_pkg::PAT_CHASE_RB;

    // a stalled pixel item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("pixel item changed under stall");

    // an off item always starts a frame, so the command side closes
    a_off_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (s_axis_tuser == lsae_pkg::OP_OFF) |=> !s_axis_tready)
        else $error("off item did not start a frame");

    // a start item emits nothing and keeps the command side open
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (s_axis_tuser == lsae_pkg::OP_START) && w_pattern_ok |=> s_axis_tready)
        else $error("start item blocked the command side");

    // tlast marks the final pixel
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == LAST_IDX5)
        else $error("tlast on wrong pixel");

    // a frame opens with pixel zero
    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) ##1 m_axis_tvalid
            |-> m_axis_tdata[4:0] == 5'd0)
        else $error("frame did not open with pixel zero");

endmodule

bind led_strip_animation_engine_top lsae_checker #(
    .PIXELS(PIXELS)
) u_lsae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
